@@ rtl/grcd_pkg.sv @@
// Package with shared types and constants of the grid ray caster.
`default_nettype none
package grcd_pkg;

   localparam int MAP_DIM_DEFAULT      = 32;
   localparam int SCREEN_WIDTH_DEFAULT = 128;

   localparam int CAM_W  = 24;
   localparam int RAY_W  = 27;
   localparam int DIV_W  = 23;
   localparam int MUL_W  = 25;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SIDE_W = 32;

   localparam logic [12:0] POS_X_RESET   = 13'd512;
   localparam logic [12:0] POS_Y_RESET   = 13'd512;
   localparam logic [15:0] DIR_X_RESET   = 16'hC000;
   localparam logic [15:0] DIR_Y_RESET   = 16'h0000;
   localparam logic [15:0] PLANE_X_RESET = 16'h0000;
   localparam logic [15:0] PLANE_Y_RESET = 16'd10813;

   localparam logic [15:0] DIST_MAX = 16'hFFFF;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   typedef enum logic [2:0] {
      CSR_POS_X   = 3'd0,
      CSR_POS_Y   = 3'd1,
      CSR_DIR_X   = 3'd2,
      CSR_DIR_Y   = 3'd3,
      CSR_PLANE_X = 3'd4,
      CSR_PLANE_Y = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CAM,
      ST_RXM,
      ST_RXA,
      ST_RYM,
      ST_RYA,
      ST_DXD,
      ST_SXM,
      ST_SXA,
      ST_DYD,
      ST_SYM,
      ST_SYA,
      ST_WALK,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ rtl/grcd_ram.sv @@
// Generic single write port RAM with one registered read port.
`default_nettype none
module grcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

@@ rtl/grid_ray_cast_distance.sv @@
// Top level of the grid ray caster: sequencer, shared divider and multiplier, map store.
//
// The req channel carries one item per handshake: op 0 writes one map cell
// (ignored when outside the map), op 1 casts the ray of screen_col. A write
// returns nothing. A cast returns one rsp item holding the column, the
// perpendicular wall distance in Q8.8, the side hit and no_hit. A cast sets
// up with a table lookup of the camera offset, four multiplies on the shared
// multiplier and two divisions on the shared restoring divider, then walks
// the map one cell per step, each step waiting on the registered read of the
// map RAM, and then loads the result; at most 2*MAP_DIM+2 steps are taken.
// One cast is in work at a time; req_ready is low while a cast is busy.
// The finished result sits in an output register, so the next item is taken
// while the receiver stalls; a second cast waits at its end until the
// output register is free. The csr port writes the camera registers at any
// edge with csr_we high; the user must use it only while the block is idle,
// which the block does not enforce. After reset the map RAM is cleared, one
// cell per cycle, over all MAP_DIM*MAP_DIM cells, with req_ready held low.
`default_nettype none
module grid_ray_cast_distance #(
   parameter int MAP_DIM      = grcd_pkg::MAP_DIM_DEFAULT,
   parameter int SCREEN_WIDTH = grcd_pkg::SCREEN_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_op,
   input  wire logic [4:0]  req_cell_row,
   input  wire logic [4:0]  req_cell_col,
   input  wire logic [7:0]  req_cell_value,
   input  wire logic [6:0]  req_screen_col,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [6:0]  rsp_col_out,
   output      logic [15:0] rsp_wall_dist,
   output      logic        rsp_hit_side,
   output      logic        rsp_no_hit,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   localparam int DEPTH = MAP_DIM * MAP_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = ($clog2(MAP_DIM) + 2 > 6) ? $clog2(MAP_DIM) + 2 : 6;
   localparam int LIMIT = 2 * MAP_DIM + 2;
   localparam int NW    = $clog2(LIMIT + 1);
   localparam int RW    = grcd_pkg::RAY_W;
   localparam int DW    = grcd_pkg::DIV_W;
   localparam int MW    = grcd_pkg::MUL_W;
   localparam int PW    = grcd_pkg::PROD_W;
   localparam int SW    = grcd_pkg::SIDE_W;
   localparam int CAMW  = grcd_pkg::CAM_W;

   grcd_pkg::state_type state_ff, state_in;

   logic [12:0] pos_x_ff, pos_y_ff;
   logic [15:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   logic [6:0]                    col_ff;
   logic signed [CAMW-1:0]        cam_ff;
   logic signed [CAMW-1:0]        cam_tab [128];
   logic [RW-1:0]                 rdx_ff, rdy_ff, mag_x, mag_y;
   logic [DW-1:0]                 delta_x_ff, delta_y_ff;
   logic [SW-1:0]                 side_x_ff, side_y_ff;
   logic                          inf_x_ff, inf_y_ff;
   logic [CW-1:0]                 cell_x_ff, cell_y_ff, nx, ny, cx_start, cy_start;
   logic                          sel_y_ff, pick_y, step_out, start_ok;
   logic [NW-1:0]                 step_cnt_ff;
   logic [15:0]                   dist_ff;
   logic                          nohit_ff;
   logic [AW-1:0]                 clr_ff, rd_addr, wr_addr, ram_waddr;
   logic [7:0]                    ram_wdata, ram_rdata;
   logic                          ram_we, wr_in_map, req_fire, rsp_load;
   logic [8:0]                    frac_x, frac_y;
   logic [SW-1:0]                 side_sel;
   logic [DW-1:0]                 delta_sel;
   logic                          inf_sel;

   logic [DW-1:0]   dvd_ff, q_ff, q_nx, div_dvd;
   logic [RW-1:0]   dvs_ff, rem_ff, rem_nx, div_dvs;
   logic [RW:0]     rem_sh;
   logic            div_ge, div_start, div_run;
   logic [4:0]      dcnt_ff;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_ff;

   logic       rsp_valid_ff;
   logic [6:0] rsp_col_ff;
   logic [15:0] rsp_dist_ff;
   logic       rsp_side_ff, rsp_nohit_ff;

   // Camera registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= grcd_pkg::POS_X_RESET;
         pos_y_ff   <= grcd_pkg::POS_Y_RESET;
         dir_x_ff   <= grcd_pkg::DIR_X_RESET;
         dir_y_ff   <= grcd_pkg::DIR_Y_RESET;
         plane_x_ff <= grcd_pkg::PLANE_X_RESET;
         plane_y_ff <= grcd_pkg::PLANE_Y_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            grcd_pkg::CSR_POS_X:   pos_x_ff   <= csr_wdata[12:0];
            grcd_pkg::CSR_POS_Y:   pos_y_ff   <= csr_wdata[12:0];
            grcd_pkg::CSR_DIR_X:   dir_x_ff   <= csr_wdata;
            grcd_pkg::CSR_DIR_Y:   dir_y_ff   <= csr_wdata;
            grcd_pkg::CSR_PLANE_X: plane_x_ff <= csr_wdata;
            grcd_pkg::CSR_PLANE_Y: plane_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Camera offset of each screen column, in Q.14.
   for (genvar g = 0; g < 128; g++) begin : g_cam
      assign cam_tab[g] = CAMW'(g * 32768 / SCREEN_WIDTH - 16384);
   end

   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == grcd_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign wr_in_map = ({27'd0, req_cell_row} < 32'(MAP_DIM)) &&
                      ({27'd0, req_cell_col} < 32'(MAP_DIM));
   assign wr_addr   = AW'(AW'(req_cell_row) * AW'(MAP_DIM)) + AW'(req_cell_col);

   assign mag_x  = rdx_ff[RW-1] ? RW'(-rdx_ff) : rdx_ff;
   assign mag_y  = rdy_ff[RW-1] ? RW'(-rdy_ff) : rdy_ff;
   assign frac_x = rdx_ff[RW-1] ? {1'b0, pos_x_ff[7:0]} : 9'd256 - {1'b0, pos_x_ff[7:0]};
   assign frac_y = rdy_ff[RW-1] ? {1'b0, pos_y_ff[7:0]} : 9'd256 - {1'b0, pos_y_ff[7:0]};

   assign cx_start = CW'(pos_x_ff[12:8]);
   assign cy_start = CW'(pos_y_ff[12:8]);
   assign start_ok = (cx_start < CW'(MAP_DIM)) && (cy_start < CW'(MAP_DIM));

   // One DDA step: pick the axis and move its cell.
   always_comb begin
      pick_y = !(!inf_x_ff && (inf_y_ff || (side_x_ff < side_y_ff)));
      nx = cell_x_ff;
      ny = cell_y_ff;
      if (pick_y) begin
         ny = rdy_ff[RW-1] ? cell_y_ff - CW'(1) : cell_y_ff + CW'(1);
      end else begin
         nx = rdx_ff[RW-1] ? cell_x_ff - CW'(1) : cell_x_ff + CW'(1);
      end
      step_out = nx[CW-1] || ny[CW-1] || (nx >= CW'(MAP_DIM)) || (ny >= CW'(MAP_DIM));
      rd_addr  = AW'(AW'(ny) * AW'(MAP_DIM)) + AW'(nx);
   end

   assign side_sel  = sel_y_ff ? side_y_ff : side_x_ff;
   assign delta_sel = sel_y_ff ? delta_y_ff : delta_x_ff;
   assign inf_sel   = sel_y_ff ? inf_y_ff : inf_x_ff;

   // Shared restoring divider, one quotient bit per cycle.
   assign rem_sh = {rem_ff, dvd_ff[DW-1]};
   assign div_ge = rem_sh >= {1'b0, dvs_ff};
   assign rem_nx = div_ge ? RW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[RW-1:0];
   assign q_nx   = {q_ff[DW-2:0], div_ge};

   always_ff @(posedge clock) begin
      if (div_start) begin
         dvd_ff  <= div_dvd;
         dvs_ff  <= div_dvs;
         rem_ff  <= '0;
         q_ff    <= '0;
         dcnt_ff <= 5'(DW - 1);
      end else if (div_run) begin
         dvd_ff  <= {dvd_ff[DW-2:0], 1'b0};
         rem_ff  <= rem_nx;
         q_ff    <= q_nx;
         dcnt_ff <= dcnt_ff - 5'd1;
      end
   end

   // Shared multiplier with registered product.
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   grcd_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_map (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(rd_addr),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grcd_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (state_ff == grcd_pkg::ST_CLEAR) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grcd_pkg::ST_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = grcd_pkg::ST_IDLE;
         grcd_pkg::ST_IDLE: begin
            if (req_fire && (req_op == grcd_pkg::OP_CAST)) state_in = grcd_pkg::ST_CAM;
         end
         grcd_pkg::ST_CAM: state_in = grcd_pkg::ST_RXM;
         grcd_pkg::ST_RXM: state_in = grcd_pkg::ST_RXA;
         grcd_pkg::ST_RXA: state_in = grcd_pkg::ST_RYM;
         grcd_pkg::ST_RYM: state_in = grcd_pkg::ST_RYA;
         grcd_pkg::ST_RYA: state_in = grcd_pkg::ST_DXD;
         grcd_pkg::ST_DXD: if (dcnt_ff == 5'd0) state_in = grcd_pkg::ST_SXM;
         grcd_pkg::ST_SXM: state_in = grcd_pkg::ST_SXA;
         grcd_pkg::ST_SXA: state_in = grcd_pkg::ST_DYD;
         grcd_pkg::ST_DYD: if (dcnt_ff == 5'd0) state_in = grcd_pkg::ST_SYM;
         grcd_pkg::ST_SYM: state_in = grcd_pkg::ST_SYA;
         grcd_pkg::ST_SYA: state_in = start_ok ? grcd_pkg::ST_WALK : grcd_pkg::ST_DONE;
         grcd_pkg::ST_WALK: state_in = step_out ? grcd_pkg::ST_DONE : grcd_pkg::ST_CHECK;
         grcd_pkg::ST_CHECK: begin
            if ((ram_rdata != 8'd0) || (step_cnt_ff == NW'(LIMIT - 1))) begin
               state_in = grcd_pkg::ST_DONE;
            end else begin
               state_in = grcd_pkg::ST_WALK;
            end
         end
         grcd_pkg::ST_DONE: if (rsp_load) state_in = grcd_pkg::ST_IDLE;
         default: state_in = grcd_pkg::ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready = (state_ff == grcd_pkg::ST_IDLE);
      div_start = 1'b0;
      div_dvd   = DW'(1) << (DW - 1);
      div_dvs   = mag_x;
      div_run   = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      ram_we    = 1'b0;
      ram_waddr = wr_addr;
      ram_wdata = req_cell_value;
      unique case (state_ff)
         grcd_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 8'd0;
         end
         grcd_pkg::ST_IDLE: begin
            ram_we    = req_fire && (req_op == grcd_pkg::OP_WRITE) && wr_in_map;
         end
         grcd_pkg::ST_DXD, grcd_pkg::ST_DYD: div_run = 1'b1;
         grcd_pkg::ST_RXM: begin
            mul_a = MW'($signed(plane_x_ff));
            mul_b = MW'(cam_ff);
         end
         grcd_pkg::ST_RYM: begin
            mul_a = MW'($signed(plane_y_ff));
            mul_b = MW'(cam_ff);
         end
         grcd_pkg::ST_RYA: div_start = 1'b1;
         grcd_pkg::ST_SXM: begin
            mul_a = $signed(MW'(frac_x));
            mul_b = $signed(MW'(delta_x_ff));
         end
         grcd_pkg::ST_SXA: begin
            div_start = 1'b1;
            div_dvs   = mag_y;
         end
         grcd_pkg::ST_SYM: begin
            mul_a = $signed(MW'(frac_y));
            mul_b = $signed(MW'(delta_y_ff));
         end
         default: ;
      endcase
   end

   // Datapath registers of the cast.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         grcd_pkg::ST_IDLE: col_ff <= req_screen_col;
         grcd_pkg::ST_CAM: cam_ff <= cam_tab[col_ff];
         grcd_pkg::ST_RXA: rdx_ff <= RW'($signed(dir_x_ff)) + mul_ff[RW+13:14];
         grcd_pkg::ST_RYA: rdy_ff <= RW'($signed(dir_y_ff)) + mul_ff[RW+13:14];
         grcd_pkg::ST_DXD: begin
            if (dcnt_ff == 5'd0) begin
               delta_x_ff <= q_nx;
               inf_x_ff   <= (rdx_ff == '0);
            end
         end
         grcd_pkg::ST_SXA: begin
            side_x_ff <= mul_ff[SW+7:8];
            cell_x_ff <= cx_start;
         end
         grcd_pkg::ST_DYD: begin
            if (dcnt_ff == 5'd0) begin
               delta_y_ff <= q_nx;
               inf_y_ff   <= (rdy_ff == '0);
            end
         end
         grcd_pkg::ST_SYA: begin
            side_y_ff   <= mul_ff[SW+7:8];
            cell_y_ff   <= cy_start;
            step_cnt_ff <= '0;
            sel_y_ff    <= 1'b0;
            dist_ff     <= 16'd0;
            nohit_ff    <= !start_ok;
         end
         grcd_pkg::ST_WALK: begin
            cell_x_ff <= nx;
            cell_y_ff <= ny;
            sel_y_ff  <= pick_y;
            if (step_out) begin
               nohit_ff <= 1'b1;
               dist_ff  <= 16'd0;
            end
         end
         grcd_pkg::ST_CHECK: begin
            if (ram_rdata != 8'd0) begin
               if (inf_sel || (side_sel[SW-1:16] != '0)) begin
                  dist_ff <= grcd_pkg::DIST_MAX;
               end else begin
                  dist_ff <= side_sel[15:0];
               end
            end else begin
               step_cnt_ff <= step_cnt_ff + NW'(1);
               if (step_cnt_ff == NW'(LIMIT - 1)) begin
                  nohit_ff <= 1'b1;
               end
               if (!inf_sel) begin
                  if (sel_y_ff) begin
                     side_y_ff <= side_y_ff + SW'(delta_y_ff);
                  end else begin
                     side_x_ff <= side_x_ff + SW'(delta_x_ff);
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_col_ff   <= col_ff;
         rsp_dist_ff  <= nohit_ff ? 16'd0 : dist_ff;
         rsp_side_ff  <= sel_y_ff;
         rsp_nohit_ff <= nohit_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_col_out   = rsp_col_ff;
   assign rsp_wall_dist = rsp_dist_ff;
   assign rsp_hit_side  = rsp_side_ff;
   assign rsp_no_hit    = rsp_nohit_ff;

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grcd_pkg::ST_CLEAR) |-> !req_ready)
      else $error("Item taken during the map clear.");

   a_nohit_zero_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_hit) |-> (rsp_wall_dist == 16'd0))
      else $error("Missed ray reports a distance.");

   a_check_after_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grcd_pkg::ST_CHECK) |-> ($past(state_ff) == grcd_pkg::ST_WALK))
      else $error("Map check without a step.");

   a_cast_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == grcd_pkg::OP_CAST)) |=> (state_ff == grcd_pkg::ST_CAM))
      else $error("Cast item did not start the setup.");

endmodule
`default_nettype wire

@@ tb/sv/grid_ray_cast_distance_tb.sv @@
// Self-checking testbench of the grid ray caster, with a scoreboard that predicts each cast.
`default_nettype none
module grid_ray_cast_distance_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID         = 32;
   localparam int COLUMNS      = 128;
   localparam int MAX_STEPS    = 2 * GRID + 2;
   localparam int IDLE_LIMIT   = 20000;
   localparam int LONG_HOLD    = 3000;
   localparam int SETTLE       = 300;
   localparam logic [2:0] CSR_SPARE_A = 3'd6;
   localparam logic [2:0] CSR_SPARE_B = 3'd7;

   typedef struct {
      logic [6:0]  col;
      logic [15:0] wall;
      logic        side;
      logic        no_hit;
   } ray_hit_type;

   class ray_scoreboard;
      bit [7:0] tiles [0:GRID*GRID-1];
      int unsigned pos_x, pos_y;
      int dir_x, dir_y, plane_x, plane_y;
      ray_hit_type pending [$];
      int errors;
      int casts_checked;
      int walls_hit;
      int rays_lost;

      function new();
         foreach (tiles[i]) tiles[i] = 8'd0;
         pos_x = grcd_pkg::POS_X_RESET;
         pos_y = grcd_pkg::POS_Y_RESET;
         dir_x = int'($signed(grcd_pkg::DIR_X_RESET));
         dir_y = int'($signed(grcd_pkg::DIR_Y_RESET));
         plane_x = int'($signed(grcd_pkg::PLANE_X_RESET));
         plane_y = int'($signed(grcd_pkg::PLANE_Y_RESET));
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            grcd_pkg::CSR_POS_X:   pos_x = v[12:0];
            grcd_pkg::CSR_POS_Y:   pos_y = v[12:0];
            grcd_pkg::CSR_DIR_X:   dir_x = int'($signed(v));
            grcd_pkg::CSR_DIR_Y:   dir_y = int'($signed(v));
            grcd_pkg::CSR_PLANE_X: plane_x = int'($signed(v));
            grcd_pkg::CSR_PLANE_Y: plane_y = int'($signed(v));
            default: ;
         endcase
      endfunction

      function ray_hit_type trace(logic [6:0] scol);
         longint cam, rd, mag, fr;
         longint grid_pos [2];
         longint stp [2];
         bit inf [2];
         longint delta [2];
         longint dside [2];
         longint pos;
         int a, n;
         bit lost, found;
         ray_hit_type r;
         cam = ((2 * longint'(scol)) << 14) / COLUMNS - 16384;
         for (int k = 0; k < 2; k++) begin
            pos = (k == 0) ? pos_x : pos_y;
            rd = (k == 0) ? dir_x + ((longint'(plane_x) * cam) >>> 14)
                          : dir_y + ((longint'(plane_y) * cam) >>> 14);
            grid_pos[k] = pos >> 8;
            stp[k] = (rd < 0) ? -1 : 1;
            inf[k] = (rd == 0);
            delta[k] = 0;
            dside[k] = 0;
            if (rd != 0) begin
               mag = (rd < 0) ? -rd : rd;
               delta[k] = (longint'(1) << 22) / mag;
               fr = pos & 255;
               if (rd > 0) fr = 256 - fr;
               dside[k] = (fr * delta[k]) >> 8;
            end
         end
         r.col = scol;
         r.wall = 16'd0;
         r.side = 1'b0;
         lost = 1'b0;
         found = 1'b0;
         if (grid_pos[0] < 0 || grid_pos[0] >= GRID ||
             grid_pos[1] < 0 || grid_pos[1] >= GRID) begin
            lost = 1'b1;
         end else begin
            for (n = 0; n < MAX_STEPS; n++) begin
               a = (!inf[0] && (inf[1] || dside[0] < dside[1])) ? 0 : 1;
               r.side = a[0];
               grid_pos[a] += stp[a];
               if (grid_pos[a] < 0 || grid_pos[a] >= GRID) begin
                  lost = 1'b1;
                  break;
               end
               if (tiles[grid_pos[1] * GRID + grid_pos[0]] != 8'd0) begin
                  found = 1'b1;
                  if (inf[a] || dside[a] > 65535) r.wall = grcd_pkg::DIST_MAX;
                  else r.wall = dside[a][15:0];
                  break;
               end
               if (!inf[a]) dside[a] += delta[a];
            end
            if (!found) lost = 1'b1;
         end
         r.no_hit = lost;
         if (lost) r.wall = 16'd0;
         return r;
      endfunction

      function void note_item(logic op, logic [4:0] row, logic [4:0] col,
                              logic [7:0] val, logic [6:0] scol);
         if (op == grcd_pkg::OP_WRITE) tiles[row * GRID + col] = val;
         else pending.push_back(trace(scol));
      endfunction

      function void check_result(ray_hit_type got);
         ray_hit_type want;
         if (pending.size() == 0) begin
            $display("%0t: result with no cast outstanding, col %0d", $time, got.col);
            errors++;
            return;
         end
         want = pending.pop_front();
         casts_checked++;
         if (got.no_hit) rays_lost++;
         else walls_hit++;
         if (got.col !== want.col) begin
            $display("%0t: col_out expected %0d actual %0d", $time, want.col, got.col);
            errors++;
         end
         if (got.wall !== want.wall) begin
            $display("%0t: wall_dist expected %0d actual %0d (col %0d)",
                     $time, want.wall, got.wall, want.col);
            errors++;
         end
         if (got.side !== want.side) begin
            $display("%0t: hit_side expected %0d actual %0d (col %0d)",
                     $time, want.side, got.side, want.col);
            errors++;
         end
         if (got.no_hit !== want.no_hit) begin
            $display("%0t: no_hit expected %0d actual %0d (col %0d)",
                     $time, want.no_hit, got.no_hit, want.col);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [4:0]  req_cell_row;
   logic [4:0]  req_cell_col;
   logic [7:0]  req_cell_value;
   logic [6:0]  req_screen_col;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [6:0]  rsp_col_out;
   logic [15:0] rsp_wall_dist;
   logic        rsp_hit_side;
   logic        rsp_no_hit;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [15:0] csr_wdata;

   ray_scoreboard ray_book;
   int  burst_left;
   int  idle_cycles;
   bit  hold_request;

   grid_ray_cast_distance u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_cell_row   (req_cell_row),
      .req_cell_col   (req_cell_col),
      .req_cell_value (req_cell_value),
      .req_screen_col (req_screen_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_col_out    (rsp_col_out),
      .rsp_wall_dist  (rsp_wall_dist),
      .rsp_hit_side   (rsp_hit_side),
      .rsp_no_hit     (rsp_no_hit),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      ray_hit_type got;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            ray_book.note_item(req_op, req_cell_row, req_cell_col, req_cell_value,
                               req_screen_col);
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            got.col = rsp_col_out;
            got.wall = rsp_wall_dist;
            got.side = rsp_hit_side;
            got.no_hit = rsp_no_hit;
            ray_book.check_result(got);
            moved = 1'b1;
         end
         if (moved || csr_we) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("grid_ray_cast_distance: mismatch");
            $finish;
         end
      end
   end

   // The receiver mixes always-ready runs, random stalls and a long hold on hold_request.
   initial begin
      int seg_left;
      bit choppy;
      seg_left = 0;
      choppy = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            if (seg_left == 0) begin
               choppy = $urandom_range(0, 1);
               seg_left = $urandom_range(1, 60);
            end
            seg_left--;
            rsp_ready <= choppy ? ($urandom_range(0, 9) < 6) : 1'b1;
         end
      end
   end

   task automatic send_item(logic op, logic [4:0] row, logic [4:0] col,
                            logic [7:0] val, logic [6:0] scol);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_op <= op;
      req_cell_row <= row;
      req_cell_col <= col;
      req_cell_value <= val;
      req_screen_col <= scol;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic cast_ray(logic [6:0] scol);
      send_item(grcd_pkg::OP_CAST, 5'($urandom), 5'($urandom), 8'($urandom), scol);
   endtask

   task automatic put_tile(logic [4:0] row, logic [4:0] col, logic [7:0] val);
      send_item(grcd_pkg::OP_WRITE, row, col, val, 7'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ray_book.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_camera(logic [12:0] px, logic [12:0] py, logic [15:0] dx,
                             logic [15:0] dy, logic [15:0] qx, logic [15:0] qy);
      logic [2:0] idx [6];
      logic [15:0] val [6];
      idx = '{grcd_pkg::CSR_POS_X, grcd_pkg::CSR_POS_Y, grcd_pkg::CSR_DIR_X,
              grcd_pkg::CSR_DIR_Y, grcd_pkg::CSR_PLANE_X, grcd_pkg::CSR_PLANE_Y};
      val = '{{3'd0, px}, {3'd0, py}, dx, dy, qx, qy};
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         ray_book.set_reg(idx[i], val[i]);
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick_vector();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'h7FFF;
         3: return 16'($signed($urandom_range(0, 4096)) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      ray_book = new();
      burst_left = 0;
      idle_cycles = 0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = grcd_pkg::OP_WRITE;
      req_cell_row = '0;
      req_cell_col = '0;
      req_cell_value = '0;
      req_screen_col = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_addr = grcd_pkg::CSR_POS_X;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset camera, empty map, then a wall ahead of the player.
      set_camera(13'd512, 13'd512, 16'hC000, 16'h0000, 16'h0000, 16'd10813);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= CSR_SPARE_A;
      csr_wdata <= 16'hFFFF;
      @(negedge clock);
      csr_addr <= CSR_SPARE_B;
      csr_wdata <= 16'h1234;
      @(negedge clock);
      csr_we <= 1'b0;
      cast_ray(7'd0);
      cast_ray(7'd127);
      cast_ray(7'd64);
      put_tile(5'd31, 5'd31, 8'd255);
      put_tile(5'd0, 5'd0, 8'd1);
      put_tile(5'd2, 5'd0, 8'd7);
      cast_ray(7'd64);
      cast_ray(7'd0);
      put_tile(5'd2, 5'd0, 8'd0);
      cast_ray(7'd64);
      drain();

      // Directed: both ray components zero, the walk climbs in y.
      set_camera(13'd512, 13'd512, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      cast_ray(7'd5);
      put_tile(5'd5, 5'd2, 8'd3);
      cast_ray(7'd100);
      drain();

      // Directed: only x moves, y is infinite.
      set_camera(13'd512, 13'd512, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
      put_tile(5'd2, 5'd9, 8'd128);
      cast_ray(7'd33);
      drain();

      // Directed: extreme positions and vectors.
      set_camera(13'd8191, 13'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      cast_ray(7'd0);
      cast_ray(7'd127);
      cast_ray(7'd64);
      drain();
      set_camera(13'd0, 13'd8191, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      cast_ray(7'd1);
      cast_ray(7'd126);
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         set_camera(13'($urandom), 13'($urandom), pick_vector(), pick_vector(),
                    pick_vector(), pick_vector());
         if (phase == 3) hold_request = 1'b1;
         for (int k = 0; k < 160; k++) begin
            if ($urandom_range(0, 99) < 45) begin
               cast_ray(7'($urandom));
            end else begin
               put_tile(5'($urandom), 5'($urandom),
                        ($urandom_range(0, 99) < 55) ? 8'd0 : 8'($urandom_range(1, 255)));
            end
         end
         drain();
      end

      repeat (SETTLE) @(posedge clock);
      $display("Checked %0d casts (%0d walls hit, %0d rays lost) over 17 camera settings,",
               ray_book.casts_checked, ray_book.walls_hit, ray_book.rays_lost);
      $display("with random map writes, receiver stalls and one long output hold.");
      if (ray_book.errors == 0 && ray_book.pending.size() == 0) begin
         $display("grid_ray_cast_distance: match");
      end else begin
         $display("grid_ray_cast_distance: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
